// File: sv/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg: shared types and constants for the ChaCha20 stream combiner
// Quarter-round function, state-machine states and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned QR_PER_DROUND = 8;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE_LO = 3'd4;
  localparam logic [2:0] REG_NONCE_HI = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } cc20_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // latch initial state from config and counter
    logic       qr_step;   // run one quarter-round
    logic [2:0] qr_sel;    // which of the eight quarter-rounds
    logic       finalize;  // feed-forward add into keystream block
    logic       emit;      // take input byte, load output register
    logic       ctr_clear; // end of message
  } cc20_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       pos_zero;
    logic       out_full;
  } cc20_stat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } cc20_quad_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic cc20_quad_t quarter_round(input cc20_quad_t q);
    cc20_quad_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/cc20_ctrl.sv
// ----------------------------------------------------------------------------
// cc20_ctrl: sequencer for block generation and byte requests
// Runs DOUBLE_ROUNDS x 8 quarter-rounds when a block is needed, then serves
// byte requests until the position wraps or a message ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  input  wire cc20_pkg::cc20_stat_t stat,
  output cc20_pkg::cc20_cmd_t     cmd
);
  import cc20_pkg::*;

  localparam int unsigned QR_TOTAL = DOUBLE_ROUNDS * QR_PER_DROUND;
  localparam int unsigned QW = $clog2(QR_TOTAL);

  cc20_state_t   state, state_next;
  logic [QW-1:0] qr_cnt, qr_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      qr_cnt <= '0;
    end else begin
      state  <= state_next;
      qr_cnt <= qr_cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    qr_cnt_next = qr_cnt;
    cmd         = '0;
    cmd.qr_sel  = qr_cnt[2:0];
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.pos_zero) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_LOAD: begin
        cmd.load    = 1'b1;
        qr_cnt_next = '0;
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.qr_step = 1'b1;
        if (qr_cnt == QW'(QR_TOTAL - 1)) begin
          state_next = ST_FINAL;
        end else begin
          qr_cnt_next = qr_cnt + QW'(1);
        end
      end
      ST_FINAL: begin
        cmd.finalize = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        // serve one byte request, then return to idle
        in_ready = !stat.out_full;
        if (in_valid && !stat.out_full) begin
          cmd.emit      = 1'b1;
          cmd.ctr_clear = in_last;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/cc20_dp.sv
// ----------------------------------------------------------------------------
// cc20_dp: ChaCha20 datapath
// Working state, one quarter-round unit, keystream block, counter, position
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [255:0]        key,
  input  wire logic [95:0]         nonce,
  input  wire cc20_pkg::cc20_cmd_t cmd,
  output cc20_pkg::cc20_stat_t     stat,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_last,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import cc20_pkg::*;

  logic [31:0] init_w [16];
  logic [31:0] work   [16];
  logic [31:0] ks     [16];
  logic [31:0] block_counter;
  logic [5:0]  byte_position;
  logic [3:0]  ia, ib, ic, id;
  cc20_quad_t  qin, qout;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      init_w[4 + i] = key[32*i +: 32];
    end
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[12] = block_counter;
    init_w[13] = nonce[31:0];
    init_w[14] = nonce[63:32];
    init_w[15] = nonce[95:64];
  end

  // column rounds for sel 0..3, diagonal rounds for 4..7
  always_comb begin
    logic [1:0] k;
    k = cmd.qr_sel[1:0];
    ia = {2'b00, k};
    if (!cmd.qr_sel[2]) begin
      ib = {2'b01, k};
      ic = {2'b10, k};
      id = {2'b11, k};
    end else begin
      ib = {2'b01, k + 2'd1};
      ic = {2'b10, k + 2'd2};
      id = {2'b11, k + 2'd3};
    end
    qin.a = work[ia];
    qin.b = work[ib];
    qin.c = work[ic];
    qin.d = work[id];
    qout  = quarter_round(qin);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= init_w;
    end else if (cmd.qr_step) begin
      work[ia] <= qout.a;
      work[ib] <= qout.b;
      work[ic] <= qout.c;
      work[id] <= qout.d;
    end
    if (cmd.finalize) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= work[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      byte_position <= '0;
    end else begin
      if (cmd.finalize) begin
        block_counter <= block_counter + 32'd1;
      end
      if (cmd.emit) begin
        if (cmd.ctr_clear) begin
          block_counter <= '0;
          byte_position <= '0;
        end else begin
          byte_position <= byte_position + 6'd1;
        end
      end
    end
  end

  assign ks_word = ks[byte_position[5:2]];
  assign ks_byte = ks_word[{byte_position[1:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= in_byte ^ ks_byte;
      out_last <= in_last;
    end
  end

  assign stat.pos_zero = (byte_position == 6'd0);
  assign stat.out_full = out_valid && !out_ready;

endmodule

`default_nettype wire

// File: sv/chacha20_stream_xor.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor: ChaCha20 (IETF) keystream XOR on a byte stream
// Timing: a request within a block passes through IDLE and OUT to acceptance;
//   a request that opens a block passes first through LOAD, the ROUND
//   quarter-round steps and FINAL. Acceptance waits while a result is stalled;
//   the result is registered and valid in the cycle after acceptance.
// Throughput: after each accepted byte the controller returns to IDLE first.
// Reset: rst synchronous; clears counter, position, FSM and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_xor #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] result_byte
  output logic             m_axis_tlast
);
  import cc20_pkg::*;

  logic [255:0] key;
  logic [95:0]  nonce;
  cc20_cmd_t    cmd;
  cc20_stat_t   stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY0:     key[63:0]     <= cfg_data;
        REG_KEY1:     key[127:64]   <= cfg_data;
        REG_KEY2:     key[191:128]  <= cfg_data;
        REG_KEY3:     key[255:192]  <= cfg_data;
        REG_NONCE_LO: nonce[63:0]   <= cfg_data;
        REG_NONCE_HI: nonce[95:64]  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cc20_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .nonce     (nonce),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

endmodule

`default_nettype wire

// File: sv/cc20_checker.sv
// ----------------------------------------------------------------------------
// cc20_checker: port-level checks for chacha20_stream_xor
// One result per request, results held under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // every accepted request shows a result on the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after request");

  // a new request is never taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken over stalled result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // results only follow requests
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(m_axis_tvalid) && m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without request");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: verif/chacha20_stream_xor_test.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor_test: self-checking bench for the ChaCha20 byte combiner
// Predicts each output byte with a local keystream generator, drives random
// messages under varying ready/valid pressure and several key/nonce settings.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_xor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cc20_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_KEY0;
  logic [63:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  chacha20_stream_xor dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // local copy of the cipher state
  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo_reg;
  logic [31:0] nonce_hi_reg;
  logic [31:0] ks_words [16];
  logic [31:0] blk_ctr;
  logic [5:0]  ks_pos;

  byte_req_t pending_bytes [$];
  byte_req_t expected_bytes [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int mismatches = 0;
  event hold_start;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] rot32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic mix(inout logic [31:0] w[16], input int a, b, c, d);
    w[a] = w[a] + w[b]; w[d] = rot32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rot32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rot32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rot32(w[b] ^ w[c], 7);
  endtask

  task automatic gen_keystream_block();
    logic [31:0] init [16];
    logic [31:0] w [16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_reg[i][31:0];
      init[5 + 2 * i] = key_reg[i][63:32];
    end
    init[12] = blk_ctr;
    init[13] = nonce_lo_reg[31:0];
    init[14] = nonce_lo_reg[63:32];
    init[15] = nonce_hi_reg;
    w = init;
    for (int r = 0; r < 10; r++) begin
      mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
      mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
      mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
      mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
  endtask

  task automatic predict_byte(byte_req_t req);
    byte_req_t res;
    if (ks_pos == 6'd0) begin
      gen_keystream_block();
      blk_ctr = blk_ctr + 32'd1;
    end
    res.data = req.data ^ ks_words[ks_pos[5:2]][8 * ks_pos[1:0] +: 8];
    res.last = req.last;
    expected_bytes.push_back(res);
    ks_pos = ks_pos + 6'd1;
    if (req.last) begin
      blk_ctr = '0;
      ks_pos = '0;
    end
  endtask

  // driver: byte stream
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_byte({s_axis_tdata, s_axis_tlast});
      if ((!s_axis_tvalid || s_axis_tready) && pending_bytes.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        {s_axis_tdata, s_axis_tlast} <= pending_bytes.pop_front();
      end else if (!s_axis_tvalid || s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    byte_req_t exp_res;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_res = expected_bytes.pop_front();
          if (exp_res.data !== m_axis_tdata || exp_res.last !== m_axis_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h/%b, got %h/%b",
                       exp_res.data, exp_res.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall, counted here while the sender keeps offering
  initial begin
    @(hold_start);
    hold_recv <= 1'b1;
    repeat (1500) @(posedge clk);
    hold_recv <= 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < REG_NONCE_LO) key_reg[idx[1:0]] = val;
    else if (idx == REG_NONCE_LO) nonce_lo_reg = val;
    else if (idx == REG_NONCE_HI) nonce_hi_reg = val[31:0];
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic drain();
    while (pending_bytes.size() > 0 || expected_bytes.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic queue_message(int len, bit all_ones);
    for (int i = 0; i < len; i++)
      pending_bytes.push_back({all_ones ? 8'hff : 8'($urandom), i == len - 1});
  endtask

  initial begin
    int len;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce_lo_reg = '0; nonce_hi_reg = '0;
    blk_ctr = '0; ks_pos = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all-zero key, then all-ones key, boundary bytes and short messages
    pending_bytes.push_back({8'h00, 1'b1});
    pending_bytes.push_back({8'hff, 1'b0});
    pending_bytes.push_back({8'h00, 1'b1});
    drain();
    for (int r = REG_KEY0; r <= REG_NONCE_HI; r++) write_reg(3'(r), '1);
    queue_message(3, 1'b1);
    queue_message(1, 1'b0);
    queue_message(16, 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 28 : 0;
      for (int r = REG_KEY0; r <= REG_NONCE_HI; r++) write_reg(3'(r), rand64());
      for (int n = 0; n < 400; ) begin
        // mostly short messages, some crossing block boundaries
        len = ($urandom_range(3) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 40);
        queue_message(len, 1'b0);
        n += len;
      end
      if (phase == 2) -> hold_start;
      drain();
    end
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
